// File: hw/rtl/pwm_soft_start_ramp_top_defines.svh
// Assertion macros shared by the soft-start ramp RTL.
`ifndef PWM_SOFT_START_RAMP_TOP_DEFINES_SVH
`define PWM_SOFT_START_RAMP_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked property, disabled while reset is high.
`define PSSR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pssr assertion failed");
// Checked property, also checked during reset.
`define PSSR_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("pssr assertion failed");
`else
`define PSSR_ASSERT(label, clk, rst, prop)
`define PSSR_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// File: hw/rtl/pssr_pkg.sv
// Shared types and constants of the PWM soft-start ramp generator.
package pssr_pkg;

   // Request operation codes
   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_START = 2'd1,
      OP_STOP  = 2'd2,
      OP_SET   = 2'd3
   } op_type;

   // CSR indexes
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_TIME  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_TOTAL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CEILING    = 2'd2;
   localparam int unsigned CSR_DATA_W = 16;

   // CSR reset values
   localparam logic [15:0] RAMP_TIME_RST  = 16'd1000;
   localparam logic [7:0]  STEP_TOTAL_RST = 8'd10;
   localparam logic [6:0]  CEILING_RST    = 7'd100;

   // Hard duty limit in percent
   localparam logic [6:0] DUTY_LIMIT = 7'd100;

   // Divider: one quotient bit per cycle over the 16-bit dividend
   localparam int unsigned DIV_STEPS = 16;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   typedef struct packed {
      op_type     operation;
      logic [7:0] requested_duty;
   } req_payload_type;

   typedef struct packed {
      logic [6:0] duty_out;
      logic       ramping;
   } rsp_payload_type;

   // Controller to datapath commands
   typedef struct packed {
      logic exec_now;   // apply a tick, stop or set-duty request
      logic div_load;   // latch divider operands for a start request
      logic div_step;   // one divider iteration
      logic div_finish; // apply the start request from the quotients
   } cmd_type;

endpackage

// File: hw/rtl/pssr_ctrl.sv
// Controller state machine: request handshake, divider sequencing, response valid.
`include "pwm_soft_start_ramp_top_defines.svh"

module pssr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  pssr_pkg::op_type  req_op,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pssr_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [pssr_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_take;

   // Ready only when idle and the response slot is free this cycle
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_op == pssr_pkg::OP_START) begin
                  cmd.div_load = 1'b1;
                  cnt_in       = '0;
                  state_in     = ST_DIV;
               end else begin
                  cmd.exec_now = 1'b1;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == pssr_pkg::DIV_CNT_W'(pssr_pkg::DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            cmd.div_finish = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response valid: set when a result is written, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.exec_now || cmd.div_finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Checks
   `PSSR_ASSERT(a_div_no_rsp, clock, reset, state_ff == ST_DIV |-> !rsp_valid_ff)
   `PSSR_ASSERT(a_done_gives_rsp, clock, reset, state_ff == ST_DONE |=> rsp_valid_ff && state_ff == ST_IDLE)
   `PSSR_ASSERT(a_start_enters_div, clock, reset, cmd.div_load |=> state_ff == ST_DIV && cnt_ff == '0)
   `PSSR_ASSERT(a_busy_not_ready, clock, reset, state_ff != ST_IDLE |-> !req_ready)

endmodule

// File: hw/rtl/pssr_datapath.sv
// Datapath: CSRs, ramp state, two-lane iterative divider and result fields.
`include "pwm_soft_start_ramp_top_defines.svh"

module pssr_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  pssr_pkg::cmd_type                   cmd,
   input  pssr_pkg::req_payload_type           req_payload,
   input  logic                                csr_we,
   input  logic [pssr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pssr_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output pssr_pkg::rsp_payload_type           rsp_payload
);

   // Restoring divider step: returns {remainder, shifted dividend/quotient}
   function automatic logic [23:0] div_iter(input logic [7:0] rem, input logic [15:0] dvd,
                                            input logic [7:0] dsr);
      logic [8:0] trial;
      logic [8:0] diff;
      logic       qbit;
      trial = {rem, dvd[15]};
      diff  = trial - {1'b0, dsr};
      qbit  = (trial >= {1'b0, dsr});
      return {(qbit ? diff[7:0] : trial[7:0]), dvd[14:0], qbit};
   endfunction

   logic [15:0] ramp_time_ff;
   logic [7:0]  step_total_ff;
   logic [6:0]  ceiling_ff;

   logic [6:0]  duty_ff, duty_in;
   logic        busy_ff, busy_in;
   logic [7:0]  steps_ff, steps_in;
   logic [15:0] ms_ff, ms_in;
   logic [15:0] period_ff, period_in;
   logic [6:0]  inc_ff, inc_in;

   logic [15:0] dvd_a_ff, dvd_b_ff;
   logic [7:0]  rem_a_ff, rem_b_ff;
   logic [7:0]  dsr_ff;
   logic [23:0] step_a, step_b;

   logic [6:0]  eff_ceil;
   logic [7:0]  eff_steps;
   logic [7:0]  add_sum;
   logic [6:0]  add_clamped;
   logic [15:0] ms_plus;
   logic [6:0]  start_inc;

   // Effective register values
   assign eff_ceil  = (ceiling_ff > pssr_pkg::DUTY_LIMIT) ? pssr_pkg::DUTY_LIMIT : ceiling_ff;
   assign eff_steps = (step_total_ff == 8'd0) ? 8'd1 : step_total_ff;

   // CSR writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_time_ff  <= pssr_pkg::RAMP_TIME_RST;
         step_total_ff <= pssr_pkg::STEP_TOTAL_RST;
         ceiling_ff    <= pssr_pkg::CEILING_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            pssr_pkg::CSR_RAMP_TIME:  ramp_time_ff  <= csr_wdata;
            pssr_pkg::CSR_STEP_TOTAL: step_total_ff <= csr_wdata[7:0];
            pssr_pkg::CSR_CEILING:    ceiling_ff    <= csr_wdata[6:0];
            default: begin
            end
         endcase
      end
   end

   // Divider lanes: step period and duty increment share the divisor
   assign step_a = div_iter(rem_a_ff, dvd_a_ff, dsr_ff);
   assign step_b = div_iter(rem_b_ff, dvd_b_ff, dsr_ff);

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         dvd_a_ff <= ramp_time_ff;
         dvd_b_ff <= {9'd0, eff_ceil};
         rem_a_ff <= '0;
         rem_b_ff <= '0;
         dsr_ff   <= eff_steps;
      end else if (cmd.div_step) begin
         rem_a_ff <= step_a[23:16];
         dvd_a_ff <= step_a[15:0];
         rem_b_ff <= step_b[23:16];
         dvd_b_ff <= step_b[15:0];
      end
   end

   // One ramp increment with ceiling clamp
   assign add_sum     = {1'b0, duty_ff} + {1'b0, inc_ff};
   assign add_clamped = (add_sum > {1'b0, eff_ceil}) ? eff_ceil : add_sum[6:0];
   assign ms_plus     = ms_ff + 16'd1;
   assign start_inc   = (dvd_b_ff == 16'd0) ? 7'd1 : dvd_b_ff[6:0];

   // Ramp state update
   always_comb begin
      duty_in   = duty_ff;
      busy_in   = busy_ff;
      steps_in  = steps_ff;
      ms_in     = ms_ff;
      period_in = period_ff;
      inc_in    = inc_ff;
      if (cmd.exec_now) begin
         unique case (req_payload.operation)
            pssr_pkg::OP_STOP: begin
               busy_in  = 1'b0;
               steps_in = '0;
               ms_in    = '0;
               duty_in  = '0;
            end
            pssr_pkg::OP_SET: begin
               busy_in  = 1'b0;
               steps_in = '0;
               ms_in    = '0;
               duty_in  = (req_payload.requested_duty > {1'b0, eff_ceil}) ?
                          eff_ceil : req_payload.requested_duty[6:0];
            end
            pssr_pkg::OP_TICK: begin
               if (busy_ff) begin
                  ms_in = ms_plus;
                  if (ms_plus >= period_ff) begin
                     ms_in = '0;
                     if (steps_ff < eff_steps) begin
                        duty_in  = add_clamped;
                        steps_in = steps_ff + 8'd1;
                     end else begin
                        duty_in  = eff_ceil;
                        busy_in  = 1'b0;
                        steps_in = '0;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end else if (cmd.div_finish) begin
         // Start: first increment applied at once, zero period ends the ramp
         period_in = dvd_a_ff;
         inc_in    = start_inc;
         ms_in     = '0;
         if (dvd_a_ff == 16'd0) begin
            duty_in  = eff_ceil;
            busy_in  = 1'b0;
            steps_in = '0;
         end else begin
            duty_in  = (start_inc > eff_ceil) ? eff_ceil : start_inc;
            busy_in  = 1'b1;
            steps_in = 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff   <= '0;
         busy_ff   <= 1'b0;
         steps_ff  <= '0;
         ms_ff     <= '0;
         period_ff <= '0;
         inc_ff    <= '0;
      end else begin
         duty_ff   <= duty_in;
         busy_ff   <= busy_in;
         steps_ff  <= steps_in;
         ms_ff     <= ms_in;
         period_ff <= period_in;
         inc_ff    <= inc_in;
      end
   end

   // State only changes once the previous response is taken, so it is the result
   assign rsp_payload.duty_out = duty_ff;
   assign rsp_payload.ramping  = busy_ff;

   // Checks
   `PSSR_ASSERT(a_duty_limit, clock, reset, duty_ff <= pssr_pkg::DUTY_LIMIT)
   `PSSR_ASSERT(a_busy_period, clock, reset, busy_ff |-> period_ff != 16'd0 && ms_ff < period_ff)
   `PSSR_ASSERT(a_idle_clean, clock, reset, !busy_ff |-> steps_ff == 8'd0 && ms_ff == 16'd0)

endmodule

// File: hw/rtl/pwm_soft_start_ramp_top.sv
// PWM soft-start ramp generator: top level joining controller and datapath.
//
// Usage:
//   req channel (valid/ready) carries one request: a 1 ms tick, start ramp,
//   stop, or set duty. Every request gives exactly one response on the rsp
//   channel (valid/ready) holding the present duty percent and ramp flag.
//   csr port: write-only, csr_we with csr_index 0 ramp time (ms), 1 step
//   count, 2 duty ceiling; write only while no request is outstanding.
// Response timing and throughput:
//   tick, stop and set-duty: response valid in the cycle after acceptance;
//   one such request per cycle while the receiver keeps rsp_ready high.
//   start: the response waits for the 16 iterations of the
//   one-bit-per-cycle divider that forms period and increment together.
// Reset (synchronous, active high): duty 0, no ramp, CSRs to 1000 ms,
//   10 steps and 100 percent.
// Stall: a response waits in place while rsp_ready is low; a new request
//   is taken in the same cycle the waiting response is taken.
module pwm_soft_start_ramp_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  pssr_pkg::req_payload_type           req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output pssr_pkg::rsp_payload_type           rsp_payload,
   input  logic                                csr_we,
   input  logic [pssr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pssr_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   pssr_pkg::cmd_type cmd;

   // Sequencing
   pssr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_payload.operation),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Ramp arithmetic and state
   pssr_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: test/tb.sv
// Self-checking testbench for the PWM soft-start ramp generator.
`timescale 1ns / 100ps

module tb;

   // Index past the last register; writes to it must change nothing
   localparam logic [pssr_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int STALL_LIMIT = 4000;
   localparam int ITEM_TARGET = 1000;

   // Duty/ramp predictor plus the queue of responses it still owes
   class ramp_checker;
      // register copies
      logic [15:0] ramp_ms;
      logic [7:0]  steps_cfg;
      logic [6:0]  ceiling_cfg;
      // ramp state
      logic [6:0]  duty;
      logic        busy;
      logic [7:0]  steps_done;
      logic [15:0] ms_elapsed;
      logic [15:0] period;
      logic [6:0]  increment;

      pssr_pkg::rsp_payload_type expected_q[$];
      int unsigned mismatches;
      int unsigned requests;
      int unsigned active_items;
      int unsigned responses;
      int unsigned ramps_done;

      function new();
         ramp_ms = pssr_pkg::RAMP_TIME_RST;
         steps_cfg = pssr_pkg::STEP_TOTAL_RST;
         ceiling_cfg = pssr_pkg::CEILING_RST;
         duty = '0;
         busy = 1'b0;
         steps_done = '0;
         ms_elapsed = '0;
         period = '0;
         increment = '0;
         mismatches = 0;
         requests = 0;
         active_items = 0;
         responses = 0;
         ramps_done = 0;
      endfunction

      function void set_register(logic [pssr_pkg::CSR_IDX_W-1:0] idx,
                                 logic [pssr_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            pssr_pkg::CSR_RAMP_TIME:  ramp_ms = value;
            pssr_pkg::CSR_STEP_TOTAL: steps_cfg = value[7:0];
            pssr_pkg::CSR_CEILING:    ceiling_cfg = value[6:0];
            default: ;
         endcase
      endfunction

      // ceiling saturates at the hard duty limit
      function logic [6:0] ceiling_now();
         return (ceiling_cfg > pssr_pkg::DUTY_LIMIT) ? pssr_pkg::DUTY_LIMIT : ceiling_cfg;
      endfunction

      // a zero step count behaves as one step
      function logic [7:0] steps_now();
         return (steps_cfg == 8'd0) ? 8'd1 : steps_cfg;
      endfunction

      function void clear_ramp();
         busy = 1'b0;
         steps_done = '0;
         ms_elapsed = '0;
      endfunction

      function void reach_ceiling();
         duty = ceiling_now();
         clear_ramp();
         ramps_done++;
      endfunction

      function void add_step();
         logic [7:0] sum;
         sum = {1'b0, duty} + {1'b0, increment};
         duty = (sum > {1'b0, ceiling_now()}) ? ceiling_now() : sum[6:0];
         steps_done = steps_done + 8'd1;
      endfunction

      // apply one accepted request and queue the response it must produce
      function void note_request(pssr_pkg::req_payload_type r);
         logic [7:0] quotient;
         pssr_pkg::rsp_payload_type rsp;
         requests++;
         if (r.operation != pssr_pkg::OP_TICK || busy)
            active_items++;
         case (r.operation)
            pssr_pkg::OP_START: begin
               period = ramp_ms / {8'd0, steps_now()};
               quotient = {1'b0, ceiling_now()} / steps_now();
               increment = (quotient == 8'd0) ? 7'd1 : quotient[6:0];
               clear_ramp();
               duty = '0;
               busy = 1'b1;
               add_step();
               // zero period: the ramp is over on the start itself
               if (period == 16'd0)
                  reach_ceiling();
            end
            pssr_pkg::OP_STOP: begin
               clear_ramp();
               duty = '0;
            end
            pssr_pkg::OP_SET: begin
               clear_ramp();
               duty = (r.requested_duty > {1'b0, ceiling_now()}) ?
                      ceiling_now() : r.requested_duty[6:0];
            end
            default: begin
               // tick: only counts while ramping
               if (busy) begin
                  ms_elapsed = ms_elapsed + 16'd1;
                  if (ms_elapsed >= period) begin
                     ms_elapsed = '0;
                     if (steps_done < steps_now())
                        add_step();
                     else
                        reach_ceiling();
                  end
               end
            end
         endcase
         rsp.duty_out = duty;
         rsp.ramping = busy;
         expected_q.push_back(rsp);
      endfunction

      function void check_response(pssr_pkg::rsp_payload_type got);
         pssr_pkg::rsp_payload_type exp_rsp;
         responses++;
         if (expected_q.size() == 0) begin
            mismatches++;
            $display("%0t: response with none expected: duty_out %0d ramping %0d",
                     $time, got.duty_out, got.ramping);
            return;
         end
         exp_rsp = expected_q.pop_front();
         if (got.duty_out !== exp_rsp.duty_out) begin
            mismatches++;
            $display("%0t: duty_out mismatch: expected %0d, got %0d",
                     $time, exp_rsp.duty_out, got.duty_out);
         end
         if (got.ramping !== exp_rsp.ramping) begin
            mismatches++;
            $display("%0t: ramping mismatch: expected %0d, got %0d",
                     $time, exp_rsp.ramping, got.ramping);
         end
      endfunction
   endclass

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   pssr_pkg::req_payload_type           req_payload;
   logic                                rsp_valid;
   logic                                rsp_ready;
   pssr_pkg::rsp_payload_type           rsp_payload;
   logic                                csr_we;
   logic [pssr_pkg::CSR_IDX_W-1:0]      csr_index;
   logic [pssr_pkg::CSR_DATA_W-1:0]     csr_wdata;

   ramp_checker               sb = new();
   pssr_pkg::req_payload_type batch_q[$];
   int                        req_calm;
   int                        rsp_calm;
   int                        rsp_hold;
   int unsigned               settings_used;

   pwm_soft_start_ramp_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Draw a random wait, with occasional runs of back-to-back traffic
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0)
         calm = $urandom_range(8, 40);
      return $urandom_range(0, 17);
   endfunction

   task automatic push_request(pssr_pkg::op_type op, logic [7:0] duty);
      pssr_pkg::req_payload_type p;
      p.operation = op;
      p.requested_duty = duty;
      batch_q.push_back(p);
   endtask

   // Drive every queued request; called and returns at a falling edge
   task automatic run_batch();
      int gap;
      foreach (batch_q[i]) begin
         gap = draw_wait(req_calm);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_valid <= 1'b1;
         req_payload <= batch_q[i];
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         sb.note_request(batch_q[i]);
         @(negedge clock);
      end
      req_valid <= 1'b0;
      batch_q.delete();
   endtask

   task automatic write_register(logic [pssr_pkg::CSR_IDX_W-1:0] idx,
                                 logic [pssr_pkg::CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      sb.set_register(idx, value);
      @(negedge clock);
   endtask

   // Write all three registers once nothing is outstanding; junk in unused bits
   task automatic apply_config(logic [15:0] ramp, logic [7:0] steps, logic [6:0] ceil);
      logic [15:0] junk;
      junk = 16'($urandom);
      while (sb.expected_q.size() != 0) @(posedge clock);
      @(negedge clock);
      write_register(pssr_pkg::CSR_RAMP_TIME, ramp);
      write_register(pssr_pkg::CSR_STEP_TOTAL, {junk[15:8], steps});
      write_register(pssr_pkg::CSR_CEILING, {junk[15:7], ceil});
      if ($urandom_range(0, 3) == 0)
         write_register(CSR_SPARE, ~junk);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // Response side: random back-pressure between responses
   initial begin : receiver
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_response(rsp_payload);
         rsp_hold = draw_wait(rsp_calm);
      end
   end

   // Watchdog: too long without any handshake ends the run
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("pwm_soft_start_ramp_top verification failed");
      $finish;
   end

   initial begin : stimulus
      logic [15:0] ramp;
      logic [7:0]  steps;
      logic [6:0]  ceil;
      int          count;
      int          pick;

      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_calm = 0;
      rsp_calm = 0;
      rsp_hold = 0;
      settings_used = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Reset settings: idle tick, start, set-duty clamping, stop
      push_request(pssr_pkg::OP_TICK, 8'd0);
      push_request(pssr_pkg::OP_START, 8'd255);
      push_request(pssr_pkg::OP_TICK, 8'd0);
      push_request(pssr_pkg::OP_SET, 8'd255);
      push_request(pssr_pkg::OP_SET, 8'd128);
      push_request(pssr_pkg::OP_SET, 8'd77);
      push_request(pssr_pkg::OP_STOP, 8'd255);
      push_request(pssr_pkg::OP_SET, 8'd0);
      run_batch();

      // Ceiling above the limit, short ramp that finishes on ticks
      apply_config(16'd3, 8'd2, 7'd127);
      push_request(pssr_pkg::OP_START, 8'd0);
      push_request(pssr_pkg::OP_TICK, 8'd0);
      push_request(pssr_pkg::OP_TICK, 8'd0);
      push_request(pssr_pkg::OP_TICK, 8'd0);
      run_batch();

      // Zero step count with zero period: done on the start
      apply_config(16'd0, 8'd0, 7'd100);
      push_request(pssr_pkg::OP_START, 8'd0);
      run_batch();

      // Zero ceiling: increment forced to one but clamped away
      apply_config(16'd2, 8'd0, 7'd0);
      push_request(pssr_pkg::OP_START, 8'd0);
      push_request(pssr_pkg::OP_TICK, 8'd0);
      push_request(pssr_pkg::OP_TICK, 8'd0);
      run_batch();

      // Largest duration and step count
      apply_config(16'hFFFF, 8'd255, 7'd100);
      push_request(pssr_pkg::OP_START, 8'd0);
      push_request(pssr_pkg::OP_TICK, 8'd0);
      run_batch();

      // Step count lowered mid-ramp ends it at the next period
      apply_config(16'd6, 8'd3, 7'd40);
      push_request(pssr_pkg::OP_START, 8'd0);
      push_request(pssr_pkg::OP_TICK, 8'd0);
      push_request(pssr_pkg::OP_TICK, 8'd0);
      run_batch();
      apply_config(16'd6, 8'd1, 7'd40);
      push_request(pssr_pkg::OP_TICK, 8'd0);
      push_request(pssr_pkg::OP_TICK, 8'd0);
      run_batch();

      // Random phases: mostly ramps driven by ticks, some interruptions
      while (sb.requests < ITEM_TARGET) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0:       ramp = 16'd0;
            1:       ramp = 16'hFFFF;
            2:       ramp = 16'($urandom);
            default: ramp = 16'($urandom_range(1, 48));
         endcase
         pick = $urandom_range(0, 9);
         case (pick)
            0:       steps = 8'd0;
            1:       steps = 8'd255;
            2:       steps = 8'd1;
            default: steps = 8'($urandom_range(1, 12));
         endcase
         pick = $urandom_range(0, 9);
         case (pick)
            0:       ceil = 7'd0;
            1:       ceil = 7'($urandom_range(101, 127));
            2:       ceil = pssr_pkg::DUTY_LIMIT;
            default: ceil = 7'($urandom_range(0, 100));
         endcase
         apply_config(ramp, steps, ceil);

         count = $urandom_range(40, 120);
         if ($urandom_range(0, 3) != 0)
            push_request(pssr_pkg::OP_START, 8'($urandom));
         repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
               push_request(pssr_pkg::OP_TICK, 8'($urandom));
            else if (pick < 88)
               push_request(pssr_pkg::OP_START, 8'($urandom));
            else if (pick < 93)
               push_request(pssr_pkg::OP_STOP, 8'($urandom));
            else
               push_request(pssr_pkg::OP_SET, 8'($urandom));
         end
         run_batch();
      end

      // Drain, then keep the clock running so stray responses are still seen
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Ran %0d requests (%0d other than idle ticks) under %0d register settings.",
               sb.requests, sb.active_items, settings_used);
      $display("Checked %0d responses; %0d ramps reached the ceiling; %0d mismatches.",
               sb.responses, sb.ramps_done, sb.mismatches);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0)
         $display("pwm_soft_start_ramp_top verification clean");
      else
         $display("pwm_soft_start_ramp_top verification failed");
      $finish;
   end

endmodule

// File: pwm_soft_start_ramp_top.f
+incdir+hw/rtl
hw/rtl/pssr_pkg.sv
hw/rtl/pssr_ctrl.sv
hw/rtl/pssr_datapath.sv
hw/rtl/pwm_soft_start_ramp_top.sv
test/tb.sv
